// ===== rtl/afcpt_pkg.sv =====
// Shared constants, register indexes and types of the ADC frame channel peak tracker.
package afcpt_pkg;

    localparam int CODE_W = 24;
    localparam int WORD_W = 32;
    localparam int FRAME_BYTES_W = 12;
    localparam int WORDS_LEFT_W = 10;

    localparam logic [WORD_W-1:0] SYNC_WORD = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] HEADER_LIMIT = 32'h8000_0000;

    // Parser phases.
    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_COUNT = 2'd2;
    localparam logic [1:0] PH_PAYLOAD = 2'd3;

    // Configuration register indexes.
    localparam logic REG_CHANNEL_ID = 1'b0;
    localparam logic REG_MAX_FRAME_BYTES = 1'b1;

    localparam logic [7:0] CHANNEL_ID_RESET = 8'd234;
    localparam logic [FRAME_BYTES_W-1:0] MAX_FRAME_BYTES_RESET = 12'd1500;

    // The four running peaks, all held as signed codes.
    typedef struct packed {
        logic signed [CODE_W-1:0] high;
        logic signed [CODE_W-1:0] high_next;
        logic signed [CODE_W-1:0] low;
        logic signed [CODE_W-1:0] low_next;
    } peaks_t;

    // Control from the parser to the statistics unit for one word.
    typedef struct packed {
        logic                     step;
        logic                     clear;
        logic                     update;
        logic signed [CODE_W-1:0] code;
    } stat_ctrl_t;

endpackage

// ===== rtl/afcpt_stats.sv =====
// Running maximum and minimum pairs of the kept ADC codes.
module afcpt_stats (
    input  logic                clk,
    input  logic                rst_n,
    input  afcpt_pkg::stat_ctrl_t ctrl,
    output afcpt_pkg::peaks_t   peaks_next
);
    import afcpt_pkg::*;

    peaks_t peaks_reg;

    always_comb
    begin
        logic signed [CODE_W-1:0] c;
        logic signed [CODE_W-1:0] hi;
        logic signed [CODE_W-1:0] hn;
        logic signed [CODE_W-1:0] lo;
        logic signed [CODE_W-1:0] ln;
        c  = ctrl.code;
        hi = ctrl.clear ? '0 : peaks_reg.high;
        hn = ctrl.clear ? '0 : peaks_reg.high_next;
        lo = ctrl.clear ? '0 : peaks_reg.low;
        ln = ctrl.clear ? '0 : peaks_reg.low_next;
        peaks_next.high      = hi;
        peaks_next.high_next = hn;
        peaks_next.low       = lo;
        peaks_next.low_next  = ln;
        if (ctrl.update)
        begin
            if (c > hi)
            begin
                peaks_next.high      = c;
                peaks_next.high_next = hi;
            end
            else if (c < hi && c > hn)
            begin
                peaks_next.high_next = c;
            end
            if (c < lo)
            begin
                peaks_next.low      = c;
                peaks_next.low_next = lo;
            end
            else if (c > lo && c < ln)
            begin
                peaks_next.low_next = c;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peaks_reg <= '0;
        end
        else if (ctrl.step)
        begin
            peaks_reg <= peaks_next;
        end
    end

endmodule

// ===== rtl/adc_frame_channel_peak_tracker.sv =====
// Top level of the ADC frame channel peak tracker: frame parser, handshakes and result register.
//
// Channel   Direction  Width  Contents
// s_*       in         32+1   tdata: data_word; tuser: restart
// m_*       out        120    tdata: sample_code, max_first, max_second, min_first, min_second
// cfg_*     in         1+12   register index, write data (channel_id, max_frame_bytes)
//
// A word moves through an input register and then a result register before a kept
// word appears on m_tvalid. One word is taken every cycle while the result side keeps
// up; the parser and peak update between the two registers are combinational. Reset
// clears the parser, the peaks and both valid flags, and loads the register defaults.
// When the result register holds an untaken result, a full input register waits and
// s_tready follows m_tready.
module adc_frame_channel_peak_tracker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // [31:0] data_word
    input  logic         s_tuser,   // [0] restart
    output logic         m_tvalid,
    input  logic         m_tready,
    // [23:0] sample_code, [46:24] max_first, [69:47] max_second,
    // [93:70] min_first, [117:94] min_second, [119:118] zero
    output logic [119:0] m_tdata,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [11:0]  cfg_wdata
);
    import afcpt_pkg::*;

    // Configuration registers.
    logic [7:0]               channel_id_reg;
    logic [FRAME_BYTES_W-1:0] max_frame_bytes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_id_reg      <= CHANNEL_ID_RESET;
            max_frame_bytes_reg <= MAX_FRAME_BYTES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CHANNEL_ID:      channel_id_reg      <= cfg_wdata[7:0];
                REG_MAX_FRAME_BYTES: max_frame_bytes_reg <= cfg_wdata;
                default:             channel_id_reg      <= channel_id_reg;
            endcase
        end
    end

    // Input register. The word advances once the result register has room.
    logic              in_valid_reg;
    logic [WORD_W-1:0] in_word_reg;
    logic              in_restart_reg;
    logic              out_valid_reg;
    logic              out_free;
    logic              advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_word_reg    <= s_tdata;
            in_restart_reg <= s_tuser;
        end
    end

    // Frame parser. A restart word is parsed as if the parser had just left reset.
    logic [1:0]              phase_reg;
    logic [1:0]              phase_next;
    logic [WORDS_LEFT_W-1:0] words_left_reg;
    logic [WORDS_LEFT_W-1:0] words_left_next;
    logic [1:0]              phase_cur;
    logic [WORDS_LEFT_W-1:0] words_cur;
    logic                    kept;

    always_comb
    begin
        phase_cur       = in_restart_reg ? PH_HUNT : phase_reg;
        words_cur       = in_restart_reg ? '0 : words_left_reg;
        phase_next      = phase_cur;
        words_left_next = words_cur;
        kept            = 1'b0;
        unique case (phase_cur)
            PH_HUNT:
            begin
                if (in_word_reg == SYNC_WORD)
                begin
                    phase_next = PH_HEADER;
                end
            end
            PH_HEADER:
            begin
                // A bad header is swallowed; hunting starts with the next word.
                phase_next = (in_word_reg < HEADER_LIMIT) ? PH_COUNT : PH_HUNT;
            end
            PH_COUNT:
            begin
                if (in_word_reg > {{(WORD_W-FRAME_BYTES_W){1'b0}}, max_frame_bytes_reg})
                begin
                    phase_next = PH_HUNT;
                end
                else
                begin
                    // Leftover bytes are dropped; counts below four give an empty frame.
                    words_left_next = in_word_reg[WORDS_LEFT_W+1:2];
                    phase_next = (in_word_reg[WORDS_LEFT_W+1:2] != '0) ? PH_PAYLOAD : PH_HUNT;
                end
            end
            PH_PAYLOAD:
            begin
                words_left_next = words_cur - 1'b1;
                if (words_left_next == '0)
                begin
                    phase_next = PH_HUNT;
                end
                kept = (in_word_reg[31:24] == channel_id_reg);
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            words_left_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            words_left_reg <= words_left_next;
        end
    end

    // Peak statistics. The boundary code 0x800000 is simply the most negative code.
    stat_ctrl_t stat_ctrl;
    peaks_t     peaks_next;

    assign stat_ctrl.step   = advance;
    assign stat_ctrl.clear  = in_restart_reg;
    assign stat_ctrl.update = kept;
    assign stat_ctrl.code   = signed'(in_word_reg[CODE_W-1:0]);

    afcpt_stats u_stats (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (stat_ctrl),
        .peaks_next (peaks_next)
    );

    // Result register.
    logic signed [CODE_W-1:0] code_reg;
    peaks_t                   peaks_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && kept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && kept)
        begin
            code_reg      <= stat_ctrl.code;
            peaks_out_reg <= peaks_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       peaks_out_reg.low_next,
                       peaks_out_reg.low,
                       peaks_out_reg.high_next[22:0],
                       peaks_out_reg.high[22:0],
                       code_reg};

    // The maximum pair stays ordered and never goes below zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (peaks_out_reg.high >= peaks_out_reg.high_next)
                          && !peaks_out_reg.high_next[CODE_W-1])
        else $error("maximum pair out of order");

    // The minimum pair stays ordered and never goes above zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (peaks_out_reg.low <= peaks_out_reg.low_next)
                          && (peaks_out_reg.low_next <= 0))
        else $error("minimum pair out of order");

    // The payload phase always has a word left to take.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (words_left_reg != '0))
        else $error("payload phase with no words left");

    // A new result only appears after a word advanced out of the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance))
        else $error("result without an advancing word");

endmodule
